// ===== src/stq_pkg.sv =====
// Package for the sorted timer event queue: opcodes, result kinds, cell types.
// No dependencies.
package stq_pkg;

   localparam logic [1:0] OP_POST   = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [2:0] KIND_POSTED   = 3'd0;
   localparam logic [2:0] KIND_REFUSED  = 3'd1;
   localparam logic [2:0] KIND_DELETED  = 3'd2;
   localparam logic [2:0] KIND_MISSED   = 3'd3;
   localparam logic [2:0] KIND_EXPIRED  = 3'd4;
   localparam logic [2:0] KIND_DONE     = 3'd5;

   localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
   localparam logic [29:0] TICK_NS_RESET = 30'd1000000;

   // one entry of the sorted chain
   typedef struct packed {
      logic        used;
      logic [5:0]  slot;
      logic [31:0] sec;
      logic [29:0] nsec;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_CARRY,
      ST_POP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       ins;      // insert new entry ahead of first later-or-equal
      logic       del;      // remove entry matching slot
      logic       pop;      // remove head
      logic [5:0] slot;
      logic [31:0] sec;
      logic [29:0] nsec;
   } cell_cmd_type;

endpackage

// ===== src/stq_if.sv =====
// Valid/ready channel interfaces for the sorted timer event queue.
// Depends on nothing.
interface stq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] expiry_sec;
   logic [29:0] expiry_nsec;
   logic [4:0]  target_slot;
   modport source (output valid, op, expiry_sec, expiry_nsec, target_slot, input ready);
   modport sink   (input valid, op, expiry_sec, expiry_nsec, target_slot, output ready);
endinterface

interface stq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [4:0] slot;
   logic       last;
   modport source (output valid, kind, slot, last, input ready);
   modport sink   (input valid, kind, slot, last, output ready);
endinterface

// ===== src/stq_cell.sv =====
// One cell of the sorted chain: holds one active entry.
// Depends on stq_pkg.
module stq_cell
   import stq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    left,       // neighbour nearer the head
   input  entry_type    right,      // neighbour further from the head
   input  logic         left_shift, // left neighbour moves right this cycle
   input  logic         left_gone,  // left or earlier neighbour removed
   output entry_type    value,
   output logic         shift_out,
   output logic         gone_out
);
   entry_type value_ff, value_in;
   logic      later;

   // new entry goes ahead of this one when this one is not earlier
   assign later = value_ff.used &&
                  ((value_ff.sec > cmd.sec) ||
                   (value_ff.sec == cmd.sec && value_ff.nsec >= cmd.nsec));
   assign shift_out = cmd.ins && (left_shift || later || !value_ff.used);
   assign gone_out  = left_gone ||
                      (cmd.del && value_ff.used && value_ff.slot == cmd.slot);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (left_shift) value_in = left;
         else if (shift_out) begin
            value_in.used = 1'b1;
            value_in.slot = cmd.slot;
            value_in.sec  = cmd.sec;
            value_in.nsec = cmd.nsec;
         end
      end else if (cmd.pop || gone_out) begin
         value_in = right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) value_ff.used <= 1'b0;
      else value_ff.used <= value_in.used;
      value_ff.slot <= value_in.slot;
      value_ff.sec  <= value_in.sec;
      value_ff.nsec <= value_in.nsec;
   end

   assign value = value_ff;
endmodule

// ===== src/sorted_timer_event_queue_unit.sv =====
// Top level of the sorted timer event queue: chain of cells, free stack, clock.
// Depends on stq_pkg, stq_if and stq_cell.
//
//  channel | dir | content
//  req     | in  | op, expiry_sec, expiry_nsec, target_slot
//  rsp     | out | kind, slot, last
//  csr     | in  | tick_ns write
//
// Post and delete: the chain updates at the accepting edge and the result item
// is offered the next cycle; input reopens once it is taken.
// Tick: the nanosecond sum is registered at acceptance; CARRY folds whole seconds
// into the seconds count (at most two carries), then POP hands off each expired
// item in turn until the head is not due, and DONE raises the done item.
// Reset is synchronous: empty chain, free stack 0..N-1 in order.
// A stalled result holds the sequencer; no item is taken until all results go.
module sorted_timer_event_queue_unit
   import stq_pkg::*;
#(
   parameter int EVENT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   stq_req_if.sink     req,
   stq_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [29:0] csr_wdata
);
   localparam int CW = $clog2(EVENT_SLOTS + 1);

   state_type state_ff, state_in;
   logic [29:0] tick_ns_ff;
   logic [31:0] now_sec_ff, now_sec_in;
   logic [30:0] now_nsec_ff, now_nsec_in;

   // free stack, held as a row of slot numbers; top at index 0
   logic [5:0]  free_ff [EVENT_SLOTS];
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic        push, pop_free;
   logic [5:0]  push_slot;

   cell_cmd_type cmd;
   entry_type    vals   [EVENT_SLOTS];
   logic         shifts [EVENT_SLOTS];
   logic         gones  [EVENT_SLOTS];
   entry_type    empty_e;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [4:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        head_due, deleted;

   assign empty_e = '{used: 1'b0, slot: 6'd0, sec: 32'd0, nsec: 30'd0};

   genvar g;
   generate
      for (g = 0; g < EVENT_SLOTS; g++) begin : g_cell
         stq_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd),
            .left      (g == 0 ? empty_e : vals[(g == 0) ? 0 : g - 1]),
            .right     (g == EVENT_SLOTS - 1 ? empty_e
                        : vals[(g == EVENT_SLOTS - 1) ? g : g + 1]),
            .left_shift(g == 0 ? 1'b0 : shifts[(g == 0) ? 0 : g - 1]),
            .left_gone (g == 0 ? 1'b0 : gones[(g == 0) ? 0 : g - 1]),
            .value(vals[g]), .shift_out(shifts[g]), .gone_out(gones[g]));
      end
   endgenerate

   assign deleted  = gones[EVENT_SLOTS - 1];
   assign head_due = vals[0].used &&
                     !((vals[0].sec > now_sec_ff) ||
                       (vals[0].sec == now_sec_ff && {1'b0, vals[0].nsec} > now_nsec_ff));
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req.valid && req.ready && req.op == OP_TICK) state_in = ST_CARRY;
         ST_CARRY: if (now_nsec_ff < {1'b0, NS_PER_SEC}) state_in = ST_POP;
         ST_POP:   if (!rsp_valid_ff && !head_due) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff) state_in = ST_IDLE;
         ST_SHIFT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{ins: 1'b0, del: 1'b0, pop: 1'b0, slot: 6'd0,
              sec: req.expiry_sec, nsec: req.expiry_nsec};
      push = 1'b0; pop_free = 1'b0; push_slot = 6'd0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in = rsp_kind_ff; rsp_slot_in = rsp_slot_ff; rsp_last_in = rsp_last_ff;
      now_sec_in = now_sec_ff; now_nsec_in = now_nsec_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid && req.ready) begin
            if (req.op == OP_POST) begin
               rsp_valid_in = 1'b1; rsp_last_in = 1'b1;
               if (free_cnt_ff == '0) begin
                  rsp_kind_in = KIND_REFUSED; rsp_slot_in = 5'd0;
               end else begin
                  cmd.ins = 1'b1; cmd.slot = free_ff[0]; pop_free = 1'b1;
                  rsp_kind_in = KIND_POSTED; rsp_slot_in = free_ff[0][4:0];
               end
            end else if (req.op == OP_DELETE) begin
               cmd.del = 1'b1; cmd.slot = {1'b0, req.target_slot};
               rsp_valid_in = 1'b1; rsp_last_in = 1'b1;
               if (deleted) begin
                  push = 1'b1; push_slot = {1'b0, req.target_slot};
                  rsp_kind_in = KIND_DELETED; rsp_slot_in = req.target_slot;
               end else begin
                  rsp_kind_in = KIND_MISSED; rsp_slot_in = 5'd0;
               end
            end else if (req.op == OP_TICK) begin
               now_nsec_in = now_nsec_ff + {1'b0, tick_ns_ff};
            end
         end
         ST_CARRY: if (now_nsec_ff >= {1'b0, NS_PER_SEC}) begin
            now_nsec_in = now_nsec_ff - {1'b0, NS_PER_SEC};
            now_sec_in  = now_sec_ff + 32'd1;
         end
         ST_POP: if (!rsp_valid_ff && head_due) begin
            cmd.pop = 1'b1; push = 1'b1; push_slot = vals[0].slot;
            rsp_valid_in = 1'b1; rsp_kind_in = KIND_EXPIRED;
            rsp_slot_in = vals[0].slot[4:0]; rsp_last_in = 1'b0;
         end
         ST_DONE: if (!rsp_valid_ff) begin
            rsp_valid_in = 1'b1; rsp_kind_in = KIND_DONE;
            rsp_slot_in = 5'd0; rsp_last_in = 1'b1;
         end
         default: ;
      endcase
      free_cnt_in = free_cnt_ff + CW'(push) - CW'(pop_free);
   end

   // free stack shifts down on push, up on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EVENT_SLOTS; i++) free_ff[i] <= 6'(i);
      end else if (push) begin
         free_ff[0] <= push_slot;
         for (int i = 1; i < EVENT_SLOTS; i++) free_ff[i] <= free_ff[i-1];
      end else if (pop_free) begin
         for (int i = 0; i < EVENT_SLOTS - 1; i++) free_ff[i] <= free_ff[i+1];
         free_ff[EVENT_SLOTS-1] <= 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ns_ff   <= TICK_NS_RESET;
         now_sec_ff   <= 32'd0;
         now_nsec_ff  <= 31'd0;
         free_cnt_ff  <= CW'(EVENT_SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) tick_ns_ff <= csr_wdata;
         now_sec_ff   <= now_sec_in;
         now_nsec_ff  <= now_nsec_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind  = rsp_kind_ff;
   assign rsp.slot  = rsp_slot_ff;
   assign rsp.last  = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= CW'(EVENT_SLOTS)) else $error("free count overflow");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(push && pop_free)) else $error("free stack push and pop together");
   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> vals[0].used) else $error("pop of empty chain");
   a_carry_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> now_nsec_ff < {1'b0, NS_PER_SEC})
      else $error("nanoseconds not normalised");
endmodule
